// ----- src/modal_plate_resonator_bank_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Modal plate resonator bank: assertion macros
// Short forms for the concurrent checks. Each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef MODAL_PLATE_RESONATOR_BANK_UNIT_MACROS_SVH
`define MODAL_PLATE_RESONATOR_BANK_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MPRB_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MPRB_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/mprb_pkg.sv -----
// ----------------------------------------------------------------------------
// Modal plate resonator bank: shared package
// Item types, request codes, fixed-point constants and control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package mprb_pkg;

	// Request codes
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// Q2.30 fraction bits, sample width and accumulator width
	localparam int FRAC_BITS = 30;
	localparam int SAMPLE_W  = 24;
	localparam int ACC_W     = 48;

	// Input item
	typedef struct packed {
		logic               req_type;
		logic [7:0]         mode_index;
		logic signed [31:0] coef_self;
		logic signed [31:0] coef_prev;
		logic signed [31:0] drive_gain;
		logic signed [31:0] pickup_gain;
		logic               mute;
		logic signed [23:0] strike_level;
		logic               strike_first_only;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic signed [23:0] sample;
	} out_item_t;

	// Controller to datapath commands
	typedef struct packed {
		logic clr_wr;      // zero one displacement entry
		logic load_wr;     // store one mode's coefficients
		logic tick_start;  // latch strike, clear accumulator
		logic issue;       // read one mode into the pipeline
		logic out_load;    // load the output register
		logic out_zero;    // muted tick: output zero
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ----- src/mprb_stream_if.sv -----
// ----------------------------------------------------------------------------
// Modal plate resonator bank: stream channel
// Valid/ready channel carrying one payload item of type T.
// ----------------------------------------------------------------------------
`default_nettype none

interface mprb_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/mprb_ctrl.sv -----
// ----------------------------------------------------------------------------
// Modal plate resonator bank: controller
// Sequences the clearing pass, loads, per-mode issue, drain and output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "modal_plate_resonator_bank_unit_macros.svh"

module mprb_ctrl
	import mprb_pkg::*;
#(
	parameter int MODES  = 256,
	parameter int MODE_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_req_type,
	input  wire logic              in_mute,
	output logic                   in_ready,
	output cmd_t                   cmd,
	output logic [MODE_W-1:0]      addr,
	input  wire sts_t              sts
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RUN   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	localparam logic [MODE_W-1:0] LAST_MODE = MODE_W'(MODES - 1);

	logic [2:0]        st_q;
	logic [MODE_W-1:0] cnt_q;
	logic              mute_q;
	logic              accept;
	logic              last;

	assign in_ready = (st_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign last     = (cnt_q == LAST_MODE);
	assign addr     = cnt_q;

	// Decode commands
	always_comb begin
		cmd            = '0;
		cmd.clr_wr     = (st_q == ST_CLEAR);
		cmd.load_wr    = accept && (in_req_type == REQ_LOAD);
		cmd.tick_start = accept && (in_req_type == REQ_TICK) && !in_mute;
		cmd.issue      = (st_q == ST_RUN);
		cmd.out_load   = (st_q == ST_DONE) && sts.out_free;
		cmd.out_zero   = mute_q;
	end

	// Advance the state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_CLEAR;
			cnt_q  <= '0;
			mute_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_CLEAR: begin
					cnt_q <= last ? '0 : cnt_q + 1'b1;
					if (last) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept && (in_req_type == REQ_TICK)) begin
						mute_q <= in_mute;
						cnt_q  <= '0;
						st_q   <= in_mute ? ST_DONE : ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= last ? '0 : cnt_q + 1'b1;
					if (last) st_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!sts.pipe_busy) st_q <= ST_DONE;
				end
				ST_DONE: begin
					if (sts.out_free) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`MPRB_ASSERT_IMPL(a_out_free, cmd.out_load, sts.out_free, "output loaded while occupied")
	`MPRB_ASSERT_NEXT(a_run_start, cmd.tick_start, cmd.issue && (addr == '0), "tick did not start at mode zero")
	`MPRB_ASSERT_IMPL(a_done_drained, st_q == ST_DONE, !sts.pipe_busy, "result taken before pipeline drained")

endmodule

`default_nettype wire

// ----- src/mprb_dpath.sv -----
// ----------------------------------------------------------------------------
// Modal plate resonator bank: datapath
// Coefficient and displacement memories, per-mode update pipeline,
// output accumulator and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mprb_dpath
	import mprb_pkg::*;
#(
	parameter int MODES  = 256,
	parameter int MODE_W = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	input  wire logic [MODE_W-1:0]     addr,
	input  wire in_item_t              item,
	output sts_t                       sts,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic signed [SAMPLE_W-1:0] sample
);

	localparam logic signed [65:0] HALF_SUM  = 66'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [63:0] HALF_PROD = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [35:0] D_MAX     = 36'sd2147483647;
	localparam logic signed [35:0] D_MIN     = -36'sd2147483648;
	localparam logic signed [ACC_W-1:0] S_MAX = ACC_W'(8388607);
	localparam logic signed [ACC_W-1:0] S_MIN = -ACC_W'(8388608);

	// Memories: {c1, c2, drive, pickup} and {x, x_prev}
	logic [127:0] coef_mem [MODES];
	logic [63:0]  disp_mem [MODES];

	logic              load_hit;
	logic [MODE_W-1:0] load_addr;

	logic signed [23:0]      strike_q;
	logic                    first_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic [MODE_W-1:0] addr_s1, addr_s2, addr_s3, addr_s4;
	logic signed [31:0] c_self_s1, c_prev_s1, drive_s1, pk_s1, x_s1, xp_s1;
	logic signed [23:0] exc_s1;
	logic signed [63:0] p_self_s2, p_prev_s2;
	logic signed [55:0] p_drive_s2;
	logic signed [31:0] pk_s2, x_s2, pk_s3, x_s3, pk_s4, x_s4, next_s4;
	logic signed [65:0] sum_s3;
	logic signed [35:0] rnd_s3;
	logic signed [63:0] prod_s5, prod_rnd;
	logic signed [33:0] term_s6;

	assign load_hit  = (32'(item.mode_index) < MODES);
	assign load_addr = MODE_W'(item.mode_index);

	// Coefficient memory: write on load, read on issue
	always_ff @(posedge clk) begin
		if (cmd.load_wr && load_hit) begin
			coef_mem[load_addr] <= {item.coef_self, item.coef_prev,
				item.drive_gain, item.pickup_gain};
		end
		if (cmd.issue) begin
			{c_self_s1, c_prev_s1, drive_s1, pk_s1} <= coef_mem[addr];
		end
	end

	// Displacement memory: clear after reset, write back, read on issue
	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			disp_mem[addr] <= '0;
		end else if (valid_s4) begin
			disp_mem[addr_s4] <= {next_s4, x_s4};
		end
		if (cmd.issue) begin
			{x_s1, xp_s1} <= disp_mem[addr];
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// Strike goes to mode zero only when asked
	assign exc_s1 = (first_q && (addr_s1 != '0)) ? 24'sd0 : strike_q;

	// Round the update sum and the output product
	assign rnd_s3   = sum_s3[65:30];
	assign prod_rnd = prod_s5 + HALF_PROD;

	// Update pipeline payload
	always_ff @(posedge clk) begin
		if (cmd.tick_start) begin
			strike_q <= item.strike_level;
			first_q  <= item.strike_first_only;
		end
		addr_s1 <= addr;
		// multiply
		p_self_s2  <= c_self_s1 * x_s1;
		p_prev_s2  <= c_prev_s1 * xp_s1;
		p_drive_s2 <= drive_s1 * exc_s1;
		pk_s2      <= pk_s1;
		x_s2       <= x_s1;
		addr_s2    <= addr_s1;
		// sum with rounding offset
		sum_s3  <= 66'(p_self_s2) + 66'(p_prev_s2) + 66'(p_drive_s2) + HALF_SUM;
		pk_s3   <= pk_s2;
		x_s3    <= x_s2;
		addr_s3 <= addr_s2;
		// saturate to 32 bits
		if (rnd_s3 > D_MAX) begin
			next_s4 <= 32'sh7fffffff;
		end else if (rnd_s3 < D_MIN) begin
			next_s4 <= 32'sh80000000;
		end else begin
			next_s4 <= rnd_s3[31:0];
		end
		pk_s4   <= pk_s3;
		x_s4    <= x_s3;
		addr_s4 <= addr_s3;
		// output weight
		prod_s5 <= next_s4 * pk_s4;
		term_s6 <= prod_rnd[63:30];
	end

	// Accumulate output terms
	always_ff @(posedge clk) begin
		if (cmd.tick_start) begin
			acc_q <= '0;
		end else if (valid_s6) begin
			acc_q <= acc_q + ACC_W'(term_s6);
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_zero) begin
				sample_q <= '0;
			end else if (acc_q > S_MAX) begin
				sample_q <= S_MAX[SAMPLE_W-1:0];
			end else if (acc_q < S_MIN) begin
				sample_q <= S_MIN[SAMPLE_W-1:0];
			end else begin
				sample_q <= acc_q[SAMPLE_W-1:0];
			end
		end
	end

	assign sts.pipe_busy = valid_s1 | valid_s2 | valid_s3 | valid_s4 | valid_s5 | valid_s6;
	assign sts.out_free  = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign sample        = sample_q;

endmodule

`default_nettype wire

// ----- src/modal_plate_resonator_bank_unit.sv -----
// ----------------------------------------------------------------------------
// Modal plate resonator bank
// Bank of damped modal oscillators for struck-plate synthesis.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Payload    | Item
//  --------+-----+------------+-----------------------------------------
//  req     | in  | in_item_t  | coefficient load or sample tick
//  rsp     | out | out_item_t | one saturated 24-bit sample per tick
//
//  A tick steps one mode per cycle through a six-stage update pipeline.
//  A muted tick skips the pipeline and gives a zero result.
//  After reset the displacement memory is cleared while req is not
//  ready. A waiting result is held in the output register; the next
//  load is taken meanwhile, a finished tick waits for it to drain.
//
`default_nettype none

module modal_plate_resonator_bank_unit
	import mprb_pkg::*;
#(
	parameter int MODES = 256
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	mprb_stream_if.sink   req,
	mprb_stream_if.source rsp
);

	localparam int MODE_W = (MODES > 1) ? $clog2(MODES) : 1;

	cmd_t              cmd;
	sts_t              sts;
	logic [MODE_W-1:0] addr;
	logic              in_ready;
	logic              out_valid;
	logic signed [SAMPLE_W-1:0] sample;
	in_item_t          item;

	assign item = req.data;

	mprb_ctrl #(
		.MODES  (MODES),
		.MODE_W (MODE_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_req_type (item.req_type),
		.in_mute     (item.mute),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.addr        (addr),
		.sts         (sts)
	);

	mprb_dpath #(
		.MODES  (MODES),
		.MODE_W (MODE_W)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.addr      (addr),
		.item      (item),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.sample    (sample)
	);

	assign req.ready       = in_ready;
	assign rsp.valid       = out_valid;
	assign rsp.data.sample = sample;

endmodule

`default_nettype wire

// ----- verif/modal_plate_resonator_bank_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modal plate resonator bank: testbench
// Sends coefficient loads and sample ticks over the req channel. A built-in
// plate model steps every mode in exact fixed point. Each sample on rsp is
// checked in order against the model or a typed row's value. Directed rows
// come first, then random loads and ticks under changing backpressure.
// ----------------------------------------------------------------------------

module modal_plate_resonator_bank_unit_tb;
	import mprb_pkg::*;

	localparam int MODES       = 256;
	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYC   = 11;
	localparam int RAND_ITEMS  = 1680;
	localparam int LONG_HOLD   = 2000;
	localparam int DRAIN_CYC   = MODES + 32;
	localparam int CYCLE_LIMIT = 3_000_000;

	// Q2.30 coefficient values
	localparam logic signed [31:0] Q_ONE  = 32'sh4000_0000;
	localparam logic signed [31:0] Q_HALF = 32'sh2000_0000;
	localparam logic signed [31:0] Q_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;
	localparam logic signed [23:0] STRIKE_MAX = 24'sh7F_FFFF;
	localparam logic signed [23:0] STRIKE_MIN = 24'sh80_0000;

	// Wide rounding and saturation bounds
	localparam logic signed [65:0] ROUND_HALF = 66'sd536870912;
	localparam logic signed [65:0] DISP_MAX   = 66'sd2147483647;
	localparam logic signed [65:0] DISP_MIN   = -66'sd2147483648;
	localparam logic signed [65:0] SMP_MAX    = 66'sd8388607;
	localparam logic signed [65:0] SMP_MIN    = -66'sd8388608;

	typedef struct {
		in_item_t          item;
		bit                typed;
		logic signed [23:0] want;
	} plate_row_t;

	logic clk;
	logic arst_n;

	mprb_stream_if #(.T(in_item_t))  req_ch ();
	mprb_stream_if #(.T(out_item_t)) rsp_ch ();

	modal_plate_resonator_bank_unit #(
		.MODES(MODES)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Plate model state
	logic signed [31:0] disp_now  [MODES];
	logic signed [31:0] disp_old  [MODES];
	logic signed [31:0] gain_self [MODES];
	logic signed [31:0] gain_prev [MODES];
	logic signed [31:0] gain_drive[MODES];
	logic signed [31:0] gain_pick [MODES];

	logic signed [23:0] pending_samples[$];
	plate_row_t         plate_script[$];

	int send_idle_pct;
	int recv_idle_pct;
	int traffic_phase;
	int cycle_count;
	int n_loads;
	int n_ticks;
	int n_muted;
	int n_checked;
	int n_errors;

	// Step the plate model by one accepted item
	function automatic void step_plate(input in_item_t it, output bit gives,
		output logic signed [23:0] smp);
		logic signed [65:0] upd;
		logic signed [65:0] term;
		logic signed [65:0] total;
		logic signed [31:0] next;
		logic signed [23:0] exc;
		gives = 1'b0;
		smp   = '0;
		total = '0;
		if (it.req_type == REQ_LOAD) begin
			if (int'(it.mode_index) < MODES) begin
				gain_self[it.mode_index]  = it.coef_self;
				gain_prev[it.mode_index]  = it.coef_prev;
				gain_drive[it.mode_index] = it.drive_gain;
				gain_pick[it.mode_index]  = it.pickup_gain;
			end
			return;
		end
		gives = 1'b1;
		if (it.mute)
			return;
		for (int m = 0; m < MODES; m++) begin
			exc = (it.strike_first_only && m != 0) ? '0 : it.strike_level;
			upd = gain_self[m] * disp_now[m] + gain_prev[m] * disp_old[m]
				+ gain_drive[m] * exc + ROUND_HALF;
			upd = upd >>> FRAC_BITS;
			if (upd > DISP_MAX)
				next = Q_MAX;
			else if (upd < DISP_MIN)
				next = Q_MIN;
			else
				next = upd[31:0];
			disp_old[m] = disp_now[m];
			disp_now[m] = next;
			term = (next * gain_pick[m] + ROUND_HALF) >>> FRAC_BITS;
			total += term;
		end
		if (total > SMP_MAX)
			smp = STRIKE_MAX;
		else if (total < SMP_MIN)
			smp = STRIKE_MIN;
		else
			smp = total[23:0];
	endfunction

	// Fully random item, every field over its whole range
	function automatic in_item_t rand_item();
		in_item_t it;
		it.req_type          = 1'($urandom_range(1));
		it.mode_index        = 8'($urandom);
		it.coef_self         = $urandom;
		it.coef_prev         = $urandom;
		it.drive_gain        = $urandom;
		it.pickup_gain       = $urandom;
		it.mute              = 1'($urandom_range(1));
		it.strike_level      = 24'($urandom);
		it.strike_first_only = 1'($urandom_range(1));
		return it;
	endfunction

	// Load of a stable damped resonator into a random mode
	function automatic in_item_t resonator_load();
		in_item_t it;
		real radius;
		real angle;
		int drv;
		int pick;
		it     = rand_item();
		radius = 0.5 + 0.49 * real'($urandom_range(1000)) / 1000.0;
		angle  = 3.14159 * real'($urandom_range(999, 1)) / 1000.0;
		drv    = int'($urandom_range(33554432)) - 16777216;
		pick   = int'($urandom_range(8388608)) - 4194304;
		it.req_type    = REQ_LOAD;
		it.coef_self   = 32'($rtoi(2.0 * radius * $cos(angle) * 1073741824.0));
		it.coef_prev   = 32'($rtoi(-radius * radius * 1073741824.0));
		it.drive_gain  = drv;
		it.pickup_gain = pick;
		return it;
	endfunction

	// Sample tick with mostly quiet or moderate strikes
	function automatic in_item_t plate_tick();
		in_item_t it;
		int pick;
		it          = rand_item();
		it.req_type = REQ_TICK;
		it.mute     = ($urandom_range(99) < 8);
		it.strike_first_only = ($urandom_range(99) < 20);
		pick = $urandom_range(99);
		if (pick < 50)
			it.strike_level = '0;
		else if (pick < 85)
			it.strike_level = 24'(int'($urandom_range(131072)) - 65536);
		return it;
	endfunction

	task automatic load_row(input logic [7:0] idx, input logic signed [31:0] c1,
		input logic signed [31:0] c2, input logic signed [31:0] drv,
		input logic signed [31:0] pick);
		plate_row_t row;
		row.item             = '0;
		row.item.req_type    = REQ_LOAD;
		row.item.mode_index  = idx;
		row.item.coef_self   = c1;
		row.item.coef_prev   = c2;
		row.item.drive_gain  = drv;
		row.item.pickup_gain = pick;
		row.typed            = 1'b0;
		row.want             = '0;
		plate_script.push_back(row);
	endtask

	task automatic tick_row(input logic mu, input logic signed [23:0] strike,
		input logic first, input bit typed, input logic signed [23:0] want);
		plate_row_t row;
		row.item                   = '0;
		row.item.req_type          = REQ_TICK;
		row.item.mute              = mu;
		row.item.strike_level      = strike;
		row.item.strike_first_only = first;
		row.typed                  = typed;
		row.want                   = want;
		plate_script.push_back(row);
	endtask

	// Offer one item, wait for it to be taken, then predict its sample
	task automatic send_item(input in_item_t it, input bit typed,
		input logic signed [23:0] want);
		bit gives;
		logic signed [23:0] smp;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= it;
		do @(posedge clk); while (!req_ch.ready);
		step_plate(it, gives, smp);
		if (it.req_type == REQ_LOAD)
			n_loads++;
		else begin
			n_ticks++;
			if (it.mute)
				n_muted++;
		end
		if (gives)
			pending_samples.push_back(typed ? want : smp);
	endtask

	// Clock
	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t timeout after %0d cycles, %0d samples pending", $time,
				cycle_count, pending_samples.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: random stalls, and one long hold-off when the last phase starts
	initial begin
		int hold_left;
		bit held_once;
		hold_left     = 0;
		held_once     = 1'b0;
		rsp_ch.ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (traffic_phase == 2 && !held_once) begin
				held_once    = 1'b1;
				hold_left    = LONG_HOLD - 1;
				rsp_ch.ready <= 1'b0;
			end else
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each sample with the oldest prediction
	always @(posedge clk) begin
		logic signed [23:0] want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_samples.size() == 0) begin
				n_errors++;
				$display("%0t unexpected sample: expected none, actual %0d", $time,
					rsp_ch.data.sample);
			end else begin
				want = pending_samples.pop_front();
				n_checked++;
				if (rsp_ch.data.sample !== want) begin
					n_errors++;
					$display("%0t sample mismatch: expected %0d, actual %0d", $time,
						want, rsp_ch.data.sample);
				end
			end
		end
	end

	// Stimulus
	initial begin
		in_item_t it;
		int pick;
		req_ch.valid  = 1'b0;
		req_ch.data   = '0;
		arst_n        = 1'b0;
		send_idle_pct = 9;
		recv_idle_pct = 46;
		traffic_phase = 0;
		cycle_count   = 0;
		n_loads       = 0;
		n_ticks       = 0;
		n_muted       = 0;
		n_checked     = 0;
		n_errors      = 0;
		for (int m = 0; m < MODES; m++) begin
			disp_now[m]   = '0;
			disp_old[m]   = '0;
			gain_self[m]  = '0;
			gain_prev[m]  = '0;
			gain_drive[m] = '0;
			gain_pick[m]  = '0;
		end
		repeat (RESET_CYC) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Clear every coefficient entry so that no tick reads an unwritten one
		for (int m = 0; m < MODES; m++) begin
			it             = rand_item();
			it.req_type    = REQ_LOAD;
			it.mode_index  = 8'(m);
			it.coef_self   = '0;
			it.coef_prev   = '0;
			it.drive_gain  = '0;
			it.pickup_gain = '0;
			send_item(it, 1'b0, '0);
		end

		// Directed rows: muting, unit gain, rounding, strike routing, extremes
		tick_row(1'b1, STRIKE_MAX, 1'b0, 1'b1, 24'sd0);
		tick_row(1'b0, 24'sd12345, 1'b0, 1'b1, 24'sd0);
		load_row(8'd0, '0, '0, Q_ONE, Q_ONE);
		tick_row(1'b0, 24'sd1000, 1'b0, 1'b1, 24'sd1000);
		tick_row(1'b0, STRIKE_MAX, 1'b0, 1'b1, STRIKE_MAX);
		tick_row(1'b0, STRIKE_MIN, 1'b0, 1'b1, STRIKE_MIN);
		tick_row(1'b1, 24'sd5, 1'b0, 1'b1, 24'sd0);
		load_row(8'd0, '0, '0, Q_HALF, Q_ONE);
		tick_row(1'b0, 24'sd1, 1'b0, 1'b1, 24'sd1);
		tick_row(1'b0, -24'sd1, 1'b0, 1'b1, 24'sd0);
		tick_row(1'b0, 24'sd3, 1'b0, 1'b1, 24'sd2);
		tick_row(1'b0, -24'sd3, 1'b0, 1'b1, -24'sd1);
		load_row(8'd0, '0, '0, Q_ONE, Q_ONE);
		load_row(8'd255, '0, '0, Q_ONE, Q_ONE);
		tick_row(1'b0, 24'sd100, 1'b1, 1'b1, 24'sd100);
		tick_row(1'b0, 24'sd100, 1'b0, 1'b1, 24'sd200);
		load_row(8'd0, Q_MAX, Q_MIN, Q_MAX, Q_MAX);
		load_row(8'd255, Q_MIN, Q_MAX, Q_MIN, Q_MIN);
		tick_row(1'b0, STRIKE_MAX, 1'b0, 1'b0, '0);
		tick_row(1'b0, STRIKE_MIN, 1'b0, 1'b0, '0);
		tick_row(1'b0, 24'sd0, 1'b0, 1'b0, '0);
		load_row(8'd128, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
		tick_row(1'b0, -24'sd1, 1'b1, 1'b0, '0);
		tick_row(1'b1, 24'sd0, 1'b0, 1'b1, 24'sd0);
		tick_row(1'b0, 24'sd0, 1'b0, 1'b0, '0);
		foreach (plate_script[i])
			send_item(plate_script[i].item, plate_script[i].typed, plate_script[i].want);

		// Random loads and ticks over three backpressure phases
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i == RAND_ITEMS / 3) begin
				traffic_phase = 1;
				send_idle_pct = 46;
				recv_idle_pct = 9;
			end else if (i == 2 * RAND_ITEMS / 3) begin
				traffic_phase = 2;
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			pick = $urandom_range(99);
			if (pick < 30)
				it = resonator_load();
			else if (pick < 36) begin
				it          = rand_item();
				it.req_type = REQ_LOAD;
			end else if (pick < 40) begin
				it             = rand_item();
				it.req_type    = REQ_LOAD;
				it.coef_self   = '0;
				it.coef_prev   = '0;
			end else
				it = plate_tick();
			send_item(it, 1'b0, '0);
		end
		@(negedge clk);
		req_ch.valid <= 1'b0;

		// Drain, then watch for stray samples
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("Sent %0d coefficient loads and %0d ticks (%0d muted); %0d samples checked.",
			n_loads, n_ticks, n_muted, n_checked);
		$display("Backpressure on each side, no idling, and a %0d-cycle output stall.",
			LONG_HOLD);
		if (n_errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
